>>> rtl/hpt_pkg.sv
// Shared types, widths and helper functions for the homogeneous point transform.
// Used by every module of the block; depends on nothing else.
package hpt_pkg;

    // Fixed word and internal widths.
    localparam int WORD_W = 32;
    localparam int PROD_W = 2 * WORD_W;
    localparam int SUM_W  = 2 * WORD_W + 2;
    localparam int REM_W  = SUM_W + WORD_W;
    localparam int NUM_ENTRIES = 16;

    // Opcodes.
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_POINT = 2'd1;
    localparam logic [1:0] OP_DIR   = 2'd2;

    localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    // Input item.
    typedef struct packed {
        logic [1:0]               opcode;
        logic [1:0]               row_index;
        logic [1:0]               col_index;
        logic signed [WORD_W-1:0] entry_value;
        logic signed [WORD_W-1:0] vx;
        logic signed [WORD_W-1:0] vy;
        logic signed [WORD_W-1:0] vz;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic signed [WORD_W-1:0] out_x;
        logic signed [WORD_W-1:0] out_y;
        logic signed [WORD_W-1:0] out_z;
        logic                     w_was_zero;
        logic                     saturated;
    } t_out_item;

    // One coordinate lane of the divider.
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [WORD_W-1:0] quo;
        logic              ovf;
        logic              qneg;
        logic              nneg;
        logic              nz;
    } t_lane;

    typedef t_lane [2:0] t_lanes;

    // Control that travels with the divider lanes.
    typedef struct packed {
        logic                   is_dir;
        logic                   w_zero;
        logic [2:0][WORD_W-1:0] dir_res;
        logic                   dir_sat;
        logic [SUM_W-1:0]       divisor;
    } t_ctl;

    // Clip a wide signed value to the word range; top bit is the clip flag.
    function automatic logic [WORD_W:0] sat_word(input logic [SUM_W-1:0] v);
        logic [SUM_W-WORD_W:0] hi;
        logic [WORD_W:0]       res;
        hi = v[SUM_W-1:WORD_W-1];
        if (hi == '0 || hi == '1) begin
            res = {1'b0, v[WORD_W-1:0]};
        end else if (v[SUM_W-1]) begin
            res = {1'b1, WORD_MIN};
        end else begin
            res = {1'b1, WORD_MAX};
        end
        return res;
    endfunction

endpackage

>>> rtl/hpt_mac.sv
// Matrix store, product stage and sum stage of the point transform.
// Depends on hpt_pkg.
module hpt_mac
    import hpt_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  t_in_item                i_item,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [3:0][SUM_W-1:0]   o_sum,
    output logic                    o_is_dir
);

    logic signed [WORD_W-1:0] r_mat [NUM_ENTRIES];
    logic signed [PROD_W-1:0] r_prod [4][3];
    logic signed [PROD_W-1:0] n_prod [4][3];
    logic signed [WORD_W-1:0] r_bias [4];
    logic signed [WORD_W-1:0] n_bias [4];
    logic                     r_dir1;
    logic                     r_v1;
    logic                     r_v2;
    logic                     r_dir2;
    logic [3:0][SUM_W-1:0]    r_sum;
    logic [3:0][SUM_W-1:0]    n_sum;
    logic                     w_en1;
    logic                     w_en2;
    logic                     w_accept;
    logic                     w_xform;
    logic signed [WORD_W-1:0] w_vec [3];

    // Stage enables: a stage loads when it is empty or its content moves on.
    assign w_en2    = !r_v2 || i_ready;
    assign w_en1    = !r_v1 || w_en2;
    assign o_ready  = w_en1;
    assign w_accept = i_valid && w_en1;
    assign w_xform  = (i_item.opcode == OP_POINT) || (i_item.opcode == OP_DIR);

    assign w_vec[0] = i_item.vx;
    assign w_vec[1] = i_item.vy;
    assign w_vec[2] = i_item.vz;

    // Matrix store; a load takes effect at its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                r_mat[i] <= '0;
            end
        end else if (w_accept && i_item.opcode == OP_LOAD) begin
            r_mat[{i_item.row_index, i_item.col_index}] <= i_item.entry_value;
        end
    end

    // Products of the input vector with the upper three rows, one per column.
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 3; k++) begin
                n_prod[c][k] = PROD_W'(w_vec[k]) * PROD_W'(r_mat[k*4+c]);
            end
            n_bias[c] = (i_item.opcode == OP_POINT) ? r_mat[12+c] : '0;
        end
    end

    // Column sums, with the translation row scaled into the product format.
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n_sum[c] = SUM_W'(r_prod[c][0]) + SUM_W'(r_prod[c][1]) + SUM_W'(r_prod[c][2])
                     + (SUM_W'(r_bias[c]) <<< FRAC_BITS);
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= w_accept && w_xform;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_prod <= n_prod;
            r_bias <= n_bias;
            r_dir1 <= (i_item.opcode == OP_DIR);
        end
        if (w_en2) begin
            r_sum  <= n_sum;
            r_dir2 <= r_dir1;
        end
    end

    assign o_valid  = r_v2;
    assign o_sum    = r_sum;
    assign o_is_dir = r_dir2;

endmodule

>>> rtl/hpt_prep.sv
// Magnitude, sign and direction rounding stage, then divider setup stage.
// Depends on hpt_pkg.
module hpt_prep
    import hpt_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [3:0][SUM_W-1:0] i_sum,
    input  logic                  i_is_dir,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_ctl                  o_ctl,
    output t_lanes                o_lanes
);

    logic [3:0][SUM_W-1:0]  r_mag;
    logic [3:0][SUM_W-1:0]  n_mag;
    logic [3:0]             r_neg;
    logic [3:0]             r_nz;
    logic                   r_dir;
    logic [2:0][WORD_W-1:0] r_dres;
    logic [2:0][WORD_W-1:0] n_dres;
    logic                   r_dsat;
    logic                   n_dsat;
    logic                   r_v3;
    logic                   r_v4;
    t_ctl                   r_ctl;
    t_ctl                   n_ctl;
    t_lanes                 r_lanes;
    t_lanes                 n_lanes;
    logic                   w_en3;
    logic                   w_en4;
    logic [WORD_W:0]        w_sat [3];
    logic [SUM_W-1:0]       w_shr [3];
    logic [REM_W-1:0]       w_dlim;

    assign w_en4   = !r_v4 || i_ready;
    assign w_en3   = !r_v3 || w_en4;
    assign o_ready = w_en3;

    // Absolute values and rounded direction results.
    always_comb begin
        n_dsat = 1'b0;
        for (int c = 0; c < 4; c++) begin
            n_mag[c] = i_sum[c][SUM_W-1] ? (SUM_W'(0) - i_sum[c]) : i_sum[c];
        end
        for (int c = 0; c < 3; c++) begin
            w_shr[c]  = $signed(i_sum[c]) >>> FRAC_BITS;
            w_sat[c]  = sat_word(w_shr[c]);
            n_dres[c] = w_sat[c][WORD_W-1:0];
            n_dsat    = n_dsat | w_sat[c][WORD_W];
        end
    end

    // Divider setup: scaled numerators and the quotient range check.
    assign w_dlim = REM_W'(r_mag[3]) << WORD_W;

    always_comb begin
        n_ctl.is_dir  = r_dir;
        n_ctl.w_zero  = !r_dir && !r_nz[3];
        n_ctl.dir_res = r_dres;
        n_ctl.dir_sat = r_dsat;
        n_ctl.divisor = r_mag[3];
        for (int c = 0; c < 3; c++) begin
            n_lanes[c].rem  = REM_W'(r_mag[c]) << FRAC_BITS;
            n_lanes[c].quo  = '0;
            n_lanes[c].ovf  = n_lanes[c].rem >= w_dlim;
            n_lanes[c].qneg = r_neg[c] ^ r_neg[3];
            n_lanes[c].nneg = r_neg[c];
            n_lanes[c].nz   = r_nz[c];
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en3) begin
                r_v3 <= i_valid;
            end
            if (w_en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_mag  <= n_mag;
            for (int c = 0; c < 4; c++) begin
                r_neg[c] <= i_sum[c][SUM_W-1];
                r_nz[c]  <= (i_sum[c] != '0);
            end
            r_dir  <= i_is_dir;
            r_dres <= n_dres;
            r_dsat <= n_dsat;
        end
        if (w_en4) begin
            r_ctl   <= n_ctl;
            r_lanes <= n_lanes;
        end
    end

    assign o_valid = r_v4;
    assign o_ctl   = r_ctl;
    assign o_lanes = r_lanes;

endmodule

>>> rtl/hpt_div_stage.sv
// One quotient bit of the restoring divider, for all three coordinate lanes.
// Depends on hpt_pkg.
module hpt_div_stage
    import hpt_pkg::*;
#(
    parameter int BIT = 0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_ctl   i_ctl,
    input  t_lanes i_lanes,
    output logic   o_valid,
    input  logic   i_ready,
    output t_ctl   o_ctl,
    output t_lanes o_lanes
);

    logic             r_v;
    t_ctl             r_ctl;
    t_lanes           r_lanes;
    t_lanes           n_lanes;
    logic             w_en;
    logic [REM_W-1:0] w_dsh;

    assign w_en    = !r_v || i_ready;
    assign o_ready = w_en;
    assign w_dsh   = REM_W'(i_ctl.divisor) << BIT;

    // Trial subtract of the shifted divisor in each lane.
    always_comb begin
        n_lanes = i_lanes;
        for (int c = 0; c < 3; c++) begin
            if (i_lanes[c].rem >= w_dsh) begin
                n_lanes[c].rem      = i_lanes[c].rem - w_dsh;
                n_lanes[c].quo[BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ctl   <= i_ctl;
            r_lanes <= n_lanes;
        end
    end

    assign o_valid = r_v;
    assign o_ctl   = r_ctl;
    assign o_lanes = r_lanes;

endmodule

>>> rtl/homogeneous_point_transform.sv
// Channel   | Handshake                      | Payload
// ----------+--------------------------------+------------------------
// input     | i_in_valid / o_in_ready        | i_in_item  (t_in_item)
// output    | o_out_valid / i_out_ready      | o_out_item (t_out_item)
//
// One item per cycle is taken while the output is not stalled; a transform result passes
// through the product, sum, two setup stages, one divider stage per quotient bit and
// the output register. Loads finish at transfer.
// Reset clears the matrix and all valid bits. Each stage holds while the next
// one is full and stalled, so bubbles close up and nothing is dropped.
// Depends on hpt_pkg, hpt_mac, hpt_prep and hpt_div_stage.
module homogeneous_point_transform
    import hpt_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic                  w_mac_valid;
    logic                  w_mac_ready;
    logic [3:0][SUM_W-1:0] w_sum;
    logic                  w_is_dir;
    logic                  w_v   [WORD_W+1];
    logic                  w_rdy [WORD_W+1];
    t_ctl                  w_ctl [WORD_W+1];
    t_lanes                w_lanes [WORD_W+1];
    logic                  r_out_valid;
    t_out_item             r_out_item;
    t_out_item             n_out_item;
    logic [WORD_W-1:0]     w_res [3];
    logic                  w_en_out;

    hpt_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_item   (i_in_item),
        .o_valid  (w_mac_valid),
        .i_ready  (w_mac_ready),
        .o_sum    (w_sum),
        .o_is_dir (w_is_dir)
    );

    hpt_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_mac_valid),
        .o_ready  (w_mac_ready),
        .i_sum    (w_sum),
        .i_is_dir (w_is_dir),
        .o_valid  (w_v[0]),
        .i_ready  (w_rdy[0]),
        .o_ctl    (w_ctl[0]),
        .o_lanes  (w_lanes[0])
    );

    // Divider chain, most significant quotient bit first.
    for (genvar j = 0; j < WORD_W; j++) begin : g_div
        hpt_div_stage #(.BIT(WORD_W - 1 - j)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[j]),
            .o_ready (w_rdy[j]),
            .i_ctl   (w_ctl[j]),
            .i_lanes (w_lanes[j]),
            .o_valid (w_v[j+1]),
            .i_ready (w_rdy[j+1]),
            .o_ctl   (w_ctl[j+1]),
            .o_lanes (w_lanes[j+1])
        );
    end

    assign w_en_out      = !r_out_valid || i_out_ready;
    assign w_rdy[WORD_W] = w_en_out;

    // Sign, clipping and the zero-w and direction cases.
    always_comb begin
        n_out_item.w_was_zero = w_ctl[WORD_W].w_zero;
        n_out_item.saturated  = 1'b0;
        for (int c = 0; c < 3; c++) begin
            if (w_ctl[WORD_W].w_zero) begin
                if (w_lanes[WORD_W][c].nz) begin
                    n_out_item.saturated = 1'b1;
                    w_res[c] = w_lanes[WORD_W][c].nneg ? WORD_MIN : WORD_MAX;
                end else begin
                    w_res[c] = '0;
                end
            end else if (w_ctl[WORD_W].is_dir) begin
                w_res[c] = w_ctl[WORD_W].dir_res[c];
            end else if (w_lanes[WORD_W][c].ovf
                         || (w_lanes[WORD_W][c].qneg
                             ? (w_lanes[WORD_W][c].quo[WORD_W-1]
                                && (|w_lanes[WORD_W][c].quo[WORD_W-2:0]))
                             : w_lanes[WORD_W][c].quo[WORD_W-1])) begin
                n_out_item.saturated = 1'b1;
                w_res[c] = w_lanes[WORD_W][c].qneg ? WORD_MIN : WORD_MAX;
            end else begin
                w_res[c] = w_lanes[WORD_W][c].qneg ? (WORD_W'(0) - w_lanes[WORD_W][c].quo)
                                                   : w_lanes[WORD_W][c].quo;
            end
        end
        if (w_ctl[WORD_W].is_dir) begin
            n_out_item.saturated = w_ctl[WORD_W].dir_sat;
        end
        n_out_item.out_x = w_res[0];
        n_out_item.out_y = w_res[1];
        n_out_item.out_z = w_res[2];
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en_out) begin
            r_out_valid <= w_v[WORD_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_out) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef NO_ASSERTIONS
    // An empty output register lets every stage move, so input is open.
    a_ready_when_empty: assert property (@(posedge i_clk)
        i_rst_n && !o_out_valid |-> o_in_ready)
        else $error("input blocked while output register is empty");

    // A zero-w result with a nonzero coordinate must report clipping.
    a_zero_w_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.w_was_zero && !o_out_item.saturated
        |-> (o_out_item.out_x == '0) && (o_out_item.out_y == '0)
            && (o_out_item.out_z == '0))
        else $error("zero w result without clip flag has nonzero coordinate");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result presented right after reset");
`endif

endmodule

>>> tb/sv/hpt_checker.sv
// Checker for the homogeneous point transform: watches both channels,
// predicts each result from its own matrix copy and compares in order.
// Depends on hpt_pkg for the item types and opcodes.
module hpt_checker
    import hpt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;

    logic signed [WORD_W-1:0] mat_copy [NUM_ENTRIES];
    t_out_item                expected_results [$];

    // Clip a wide value to the word range and note any clipping.
    function automatic logic [WORD_W-1:0] clip_word(input logic signed [127:0] v,
                                                    inout bit clipped);
        logic signed [127:0] lo_lim;
        logic signed [127:0] hi_lim;
        lo_lim = -(128'sd1 <<< (WORD_W - 1));
        hi_lim = (128'sd1 <<< (WORD_W - 1)) - 1;
        if (v < lo_lim) begin
            clipped = 1'b1;
            return WORD_MIN;
        end
        if (v > hi_lim) begin
            clipped = 1'b1;
            return WORD_MAX;
        end
        return v[WORD_W-1:0];
    endfunction

    // Row vector times matrix, with perspective divide for points.
    function automatic t_out_item transform_item(input t_in_item it);
        logic signed [127:0] coord [3];
        logic signed [127:0] acc [4];
        logic signed [127:0] entry;
        logic [127:0]        num;
        logic [127:0]        den;
        logic [127:0]        quo;
        logic signed [127:0] q_signed;
        logic [WORD_W-1:0]   res [3];
        bit                  clipped;
        bit                  w_zero;
        t_out_item           r;
        clipped = 1'b0;
        w_zero = 1'b0;
        coord[0] = it.vx;
        coord[1] = it.vy;
        coord[2] = it.vz;
        for (int c = 0; c < 4; c++) begin
            acc[c] = 0;
            for (int k = 0; k < 3; k++) begin
                entry = mat_copy[k*4 + c];
                acc[c] += coord[k] * entry;
            end
        end
        if (it.opcode == OP_DIR) begin
            for (int c = 0; c < 3; c++) res[c] = clip_word(acc[c] >>> FRAC, clipped);
        end else begin
            for (int c = 0; c < 4; c++) begin
                entry = mat_copy[12 + c];
                acc[c] += entry <<< FRAC;
            end
            if (acc[3] == 0) begin
                // Zero w: each coordinate goes to the end matching its numerator sign.
                w_zero = 1'b1;
                for (int c = 0; c < 3; c++) begin
                    if (acc[c] == 0) begin
                        res[c] = '0;
                    end else begin
                        clipped = 1'b1;
                        res[c] = (acc[c] < 0) ? WORD_MIN : WORD_MAX;
                    end
                end
            end else begin
                den = (acc[3] < 0) ? -acc[3] : acc[3];
                for (int c = 0; c < 3; c++) begin
                    num = (acc[c] < 0) ? -acc[c] : acc[c];
                    num = num << FRAC;
                    quo = num / den;
                    q_signed = quo;
                    if ((acc[c] < 0) != (acc[3] < 0)) q_signed = -q_signed;
                    res[c] = clip_word(q_signed, clipped);
                end
            end
        end
        r.out_x = res[0];
        r.out_y = res[1];
        r.out_z = res[2];
        r.w_was_zero = w_zero;
        r.saturated = clipped;
        return r;
    endfunction

    // Track input transfers and compare output transfers at each rising edge.
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ENTRIES; i++) mat_copy[i] = '0;
            expected_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no expected result");
                    o_fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (i_out_item.out_x !== exp_r.out_x) begin
                        $error("out_x expected %h actual %h", exp_r.out_x, i_out_item.out_x);
                        o_fail_count++;
                    end
                    if (i_out_item.out_y !== exp_r.out_y) begin
                        $error("out_y expected %h actual %h", exp_r.out_y, i_out_item.out_y);
                        o_fail_count++;
                    end
                    if (i_out_item.out_z !== exp_r.out_z) begin
                        $error("out_z expected %h actual %h", exp_r.out_z, i_out_item.out_z);
                        o_fail_count++;
                    end
                    if (i_out_item.w_was_zero !== exp_r.w_was_zero) begin
                        $error("w_was_zero expected %b actual %b",
                               exp_r.w_was_zero, i_out_item.w_was_zero);
                        o_fail_count++;
                    end
                    if (i_out_item.saturated !== exp_r.saturated) begin
                        $error("saturated expected %b actual %b",
                               exp_r.saturated, i_out_item.saturated);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (i_in_item.opcode)
                    OP_LOAD: begin
                        mat_copy[{i_in_item.row_index, i_in_item.col_index}] =
                            i_in_item.entry_value;
                    end
                    OP_POINT, OP_DIR: begin
                        expected_results.push_back(transform_item(i_in_item));
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending = expected_results.size();
    end

endmodule

>>> tb/sv/tb_homogeneous_point_transform.sv
// Top of the homogeneous point transform testbench: clock, reset, stimulus
// and verdict. Depends on hpt_pkg, hpt_checker and the block itself.
module tb_homogeneous_point_transform;
    import hpt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1500;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;
    int        fail_count;
    int        pending;
    bit        no_idle = 1'b0;

    homogeneous_point_transform u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    hpt_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_item   (o_out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("homogeneous_point_transform verification failed");
        $finish;
    end

    // Receiver: random stalls, one long hold-off, and a stretch always ready.
    initial begin
        int cyc;
        cyc = 0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc >= 500 && cyc < 800) i_out_ready = 1'b0;
            else if (cyc >= 1000 && cyc < 1500) i_out_ready = 1'b1;
            else i_out_ready = ($urandom_range(99) >= 28);
        end
    end

    // A word biased toward extremes and small values.
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(9))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return '0;
            3, 4: return $urandom();
            5: return 32'h0001_0000;
            6: return -32'sh0001_0000;
            default: return 32'($signed($urandom_range(65536 * 8))) - 32'sh0004_0000;
        endcase
    endfunction

    // Offer one item and hold it until the block takes it. The caller stands
    // at a falling edge, so items can follow each other with no gap.
    task automatic send_item(input t_in_item it);
        while (!no_idle && $urandom_range(99) < 28) begin
            i_in_valid = 1'b0;
            i_in_item = '0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_item = it;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic load_entry(input logic [1:0] r, input logic [1:0] c,
                              input logic [WORD_W-1:0] v);
        t_in_item it;
        it = '0;
        it.opcode = OP_LOAD;
        it.row_index = r;
        it.col_index = c;
        it.entry_value = v;
        send_item(it);
    endtask

    task automatic send_vector(input logic [1:0] op, input logic [WORD_W-1:0] x,
                               input logic [WORD_W-1:0] y, input logic [WORD_W-1:0] z);
        t_in_item it;
        it = '0;
        it.opcode = op;
        it.vx = x;
        it.vy = y;
        it.vz = z;
        send_item(it);
    endtask

    initial begin
        t_in_item it;
        int k;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Zero matrix after reset: zero w with zero numerators.
        send_vector(OP_POINT, 32'h0001_0000, WORD_MIN, WORD_MAX);
        send_vector(OP_DIR, WORD_MAX, WORD_MIN, 32'h0002_0000);
        // Zero w with nonzero numerators, then a nonzero w.
        load_entry(2'd3, 2'd0, 32'h0003_0000);
        load_entry(2'd3, 2'd1, -32'sh0002_0000);
        send_vector(OP_POINT, '0, '0, '0);
        load_entry(2'd3, 2'd3, 32'h0002_0000);
        send_vector(OP_POINT, 32'h0001_8000, '0, 32'h0000_0001);
        // Identity upper part, divides, rounding of negative directions.
        for (int i = 0; i < 3; i++) load_entry(2'(i), 2'(i), 32'h0001_0000);
        send_vector(OP_POINT, -32'sh0000_0003, 32'h7fff_ffff, 32'h8000_0000);
        send_vector(OP_DIR, -32'sh0000_0003, 32'h7fff_ffff, 32'h8000_0000);
        // Large entries force clipping on both ends.
        load_entry(2'd0, 2'd0, WORD_MAX);
        load_entry(2'd1, 2'd1, WORD_MIN);
        send_vector(OP_DIR, WORD_MAX, WORD_MAX, 32'h0001_0000);
        send_vector(OP_POINT, WORD_MIN, WORD_MIN, '0);
        load_entry(2'd3, 2'd3, 32'h0000_0001);
        send_vector(OP_POINT, 32'h0010_0000, -32'sh0010_0000, '0);
        // Unused opcode leaves everything untouched.
        it = '0;
        it.opcode = OP_UNUSED;
        it.entry_value = WORD_MAX;
        send_item(it);
        send_vector(OP_POINT, 32'hffff_ffff, 32'h5555_aaaa, 32'haaaa_5555);

        // Random part: mostly transforms, with loads and some unused opcodes.
        k = 0;
        while (k < RANDOM_ITEMS) begin
            no_idle = (k >= 600 && k < 900);
            it.row_index = $urandom_range(3);
            it.col_index = $urandom_range(3);
            it.entry_value = pick_word();
            it.vx = pick_word();
            it.vy = pick_word();
            it.vz = pick_word();
            case ($urandom_range(19))
                0, 1, 2, 3: it.opcode = OP_LOAD;
                4: it.opcode = OP_UNUSED;
                5, 6, 7, 8, 9, 10: it.opcode = OP_DIR;
                default: it.opcode = OP_POINT;
            endcase
            // Sometimes make w vanish so the zero-w path stays busy.
            if (it.opcode == OP_LOAD && $urandom_range(15) == 0) it.entry_value = '0;
            send_item(it);
            if (it.opcode != OP_UNUSED) k++;
        end
        no_idle = 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("homogeneous_point_transform verification clean");
        end else begin
            $display("homogeneous_point_transform verification failed");
        end
        $finish;
    end

endmodule

>>> homogeneous_point_transform.f
rtl/hpt_pkg.sv
rtl/hpt_mac.sv
rtl/hpt_prep.sv
rtl/hpt_div_stage.sv
rtl/homogeneous_point_transform.sv
tb/sv/hpt_checker.sv
tb/sv/tb_homogeneous_point_transform.sv
